@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sha1csg_pkg.sv @@
// Shared constants, types and functions of the SHA-1 chained salt generator.
`default_nettype none
package sha1csg_pkg;

    localparam int CHAIN_WORDS  = 5;
    localparam int DIGEST_BYTES = 20;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int WIDX_W       = $clog2(CHAIN_WORDS);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_GEN  = 1'b1;

    localparam logic [31:0] SALT_WORD = 32'hF672ABD1;
    localparam logic [31:0] SALT_BLK  = {SALT_WORD[7:0], SALT_WORD[15:8],
                                         SALT_WORD[23:16], SALT_WORD[31:24]};
    localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
    localparam logic [31:0] LEN_CHAIN = 32'd160;
    localparam logic [31:0] LEN_SALT  = 32'd192;

    typedef struct packed {
        logic init;
        logic shift_in;
        logic round;
    } core_ctl_t;

    function automatic logic [31:0] iv_word(input logic [WIDX_W-1:0] sel);
        logic [31:0] v;
        case (sel)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] idx);
        logic [31:0] v;
        if (idx < 7'd20)
            v = 32'h5A827999;
        else if (idx < 7'd40)
            v = 32'h6ED9EBA1;
        else if (idx < 7'd60)
            v = 32'h8F1BBCDC;
        else
            v = 32'hCA62C1D6;
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha1csg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sha1csg_ram #(
    parameter int DEPTH = 5,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/sha1csg_core.sv @@
// SHA-1 round engine: message schedule shift line and one round per cycle while ctl.round is high.
`default_nettype none
module sha1csg_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha1csg_pkg::core_ctl_t         ctl,
    input  logic [31:0]                    w_in,
    input  logic [6:0]                     round_idx,
    input  logic [sha1csg_pkg::WIDX_W-1:0] word_sel,
    output logic [31:0]                    digest_word
);
    import sha1csg_pkg::*;

    logic [31:0] w_reg [BLOCK_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] mix, sched, w_new, f, t, sel_word;

    assign mix   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched = {mix[30:0], mix[31]};
    assign w_new = ctl.shift_in ? w_in : sched;

    always_comb
    begin
        if (round_idx < 7'd20)
            f = (b_reg & c_reg) | (~b_reg & d_reg);
        else if (round_idx < 7'd40)
            f = b_reg ^ c_reg ^ d_reg;
        else if (round_idx < 7'd60)
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        else
            f = b_reg ^ c_reg ^ d_reg;
    end

    assign t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + round_k(round_idx) + w_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.shift_in || ctl.round)
        begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++)
            begin
                w_reg[j] <= w_reg[j + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end
        else if (ctl.init)
        begin
            a_reg <= iv_word(3'd0);
            b_reg <= iv_word(3'd1);
            c_reg <= iv_word(3'd2);
            d_reg <= iv_word(3'd3);
            e_reg <= iv_word(3'd4);
        end
        else if (ctl.round)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    always_comb
    begin
        case (word_sel)
            3'd0:    sel_word = a_reg;
            3'd1:    sel_word = b_reg;
            3'd2:    sel_word = c_reg;
            3'd3:    sel_word = d_reg;
            3'd4:    sel_word = e_reg;
            default: sel_word = '0;
        endcase
    end

    assign digest_word = iv_word(word_sel) + sel_word;

endmodule
`default_nettype wire

@@ rtl/sha1_chained_salt_generator.sv @@
// Top level of the SHA-1 chained salt generator: sequencer, chain and digest stores.
// Usage:
//   Command channel: an item is taken at a rising edge with start high and busy low.
//   action = load writes seed_word into chain word word_index (0..4) in that cycle and
//   marks the block seeded; busy stays low. Indexes above 4 are dropped.
//   action = generate with byte_count 1..20 (larger counts saturate to 20, zero is
//   dropped) hashes the chain into a new chain, then hashes salt plus new chain and
//   emits the first byte_count digest bytes, one per cycle, each marked by strobe.
//   last_byte flags the final byte; unseeded flags output made before any load.
//   A generate item keeps busy high for two passes of block fill from the chain
//   store, 80 rounds on the single round engine and writeback of the five digest
//   words, then one byte per cycle out of the digest store.
//   Results cannot be held off: each byte is marked by strobe for one cycle only.
//   Reset clears the chain to zero (per-word valid bits) and the seeded mark.
`default_nettype none
`include "assert_macros.svh"
module sha1_chained_salt_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [2:0]  word_index,
    input  logic [31:0] seed_word,
    input  logic [4:0]  byte_count,
    output logic        strobe,
    output logic [7:0]  random_byte,
    output logic        last_byte,
    output logic        unseeded
);
    import sha1csg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LD1  = 3'd1;
    localparam logic [2:0] S_RND1 = 3'd2;
    localparam logic [2:0] S_WB1  = 3'd3;
    localparam logic [2:0] S_LD2  = 3'd4;
    localparam logic [2:0] S_RND2 = 3'd5;
    localparam logic [2:0] S_WB2  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [6:0]             cnt_reg, cnt_next;
    logic [4:0]             n_reg, n_next;
    logic                   uns_reg, uns_next;
    logic                   seeded_reg, seeded_next;
    logic [CHAIN_WORDS-1:0] vld_reg, vld_next;
    logic [WIDX_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [1:0]             lane_reg, lane_next;
    logic                   strobe_reg, strobe_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic                   unseeded_reg, unseeded_next;

    logic                   accept;
    logic [6:0]             cm1;
    logic [3:0]             blk_k;
    logic [31:0]            chain_eff, blk_word;
    core_ctl_t              ctl;
    logic [31:0]            digest_word;

    logic                   ch_we;
    logic [WIDX_W-1:0]      ch_waddr, ch_raddr;
    logic [31:0]            ch_wdata, ch_rdata;
    logic                   dg_we;
    logic [WIDX_W-1:0]      dg_raddr;
    logic [31:0]            dg_rdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cm1    = cnt_reg - 7'd1;
    assign blk_k  = cm1[3:0];

    assign chain_eff = ((rd_addr_reg < WIDX_W'(CHAIN_WORDS)) && vld_reg[rd_addr_reg])
                       ? ch_rdata : 32'h0;

    always_comb
    begin
        blk_word = 32'h0;
        if (state_reg == S_LD1)
        begin
            if (blk_k < 4'd5)
                blk_word = chain_eff;
            else if (blk_k == 4'd5)
                blk_word = PAD_WORD;
            else if (blk_k == 4'd15)
                blk_word = LEN_CHAIN;
        end
        else
        begin
            if (blk_k == 4'd0)
                blk_word = SALT_BLK;
            else if (blk_k < 4'd6)
                blk_word = chain_eff;
            else if (blk_k == 4'd6)
                blk_word = PAD_WORD;
            else if (blk_k == 4'd15)
                blk_word = LEN_SALT;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        uns_next      = uns_reg;
        seeded_next   = seeded_reg;
        vld_next      = vld_reg;
        rd_addr_next  = rd_addr_reg;
        lane_next     = lane_reg;
        strobe_next   = 1'b0;
        byte_next     = byte_reg;
        last_next     = last_reg;
        unseeded_next = unseeded_reg;
        ctl           = '0;
        ch_we         = 1'b0;
        ch_waddr      = word_index;
        ch_wdata      = seed_word;
        ch_raddr      = cnt_reg[2:0];
        dg_we         = 1'b0;
        dg_raddr      = cnt_reg[4:2];

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_LOAD) && (word_index < WIDX_W'(CHAIN_WORDS)))
                begin
                    ch_we                = 1'b1;
                    vld_next[word_index] = 1'b1;
                    seeded_next          = 1'b1;
                end
                else if (accept && (action == ACT_GEN) && (byte_count != 5'd0))
                begin
                    n_next     = (byte_count > 5'(DIGEST_BYTES)) ? 5'(DIGEST_BYTES)
                                                                 : byte_count;
                    uns_next   = !seeded_reg;
                    cnt_next   = 7'd0;
                    state_next = S_LD1;
                end
            end
            S_LD1, S_LD2:
            begin
                ch_raddr     = (state_reg == S_LD1) ? cnt_reg[2:0] : cnt_reg[2:0] - 3'd1;
                rd_addr_next = ch_raddr;
                ctl.init     = (cnt_reg == 7'd0);
                ctl.shift_in = (cnt_reg != 7'd0);
                cnt_next     = cnt_reg + 7'd1;
                if (cnt_reg == 7'(BLOCK_WORDS))
                begin
                    cnt_next   = 7'd0;
                    state_next = (state_reg == S_LD1) ? S_RND1 : S_RND2;
                end
            end
            S_RND1, S_RND2:
            begin
                ctl.round = 1'b1;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'(ROUNDS - 1))
                begin
                    cnt_next   = 7'd0;
                    state_next = (state_reg == S_RND1) ? S_WB1 : S_WB2;
                end
            end
            S_WB1:
            begin
                ch_we                 = 1'b1;
                ch_waddr              = cnt_reg[2:0];
                ch_wdata              = digest_word;
                vld_next[cnt_reg[2:0]] = 1'b1;
                cnt_next              = cnt_reg + 7'd1;
                if (cnt_reg == 7'(CHAIN_WORDS - 1))
                begin
                    cnt_next   = 7'd0;
                    state_next = S_LD2;
                end
            end
            S_WB2:
            begin
                dg_we    = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(CHAIN_WORDS - 1))
                begin
                    cnt_next   = 7'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                lane_next = cnt_reg[1:0];
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0)
                begin
                    strobe_next   = 1'b1;
                    last_next     = (cnt_reg == {2'b00, n_reg});
                    unseeded_next = uns_reg;
                    case (lane_reg)
                        2'd0:    byte_next = dg_rdata[31:24];
                        2'd1:    byte_next = dg_rdata[23:16];
                        2'd2:    byte_next = dg_rdata[15:8];
                        default: byte_next = dg_rdata[7:0];
                    endcase
                end
                if (cnt_reg == {2'b00, n_reg})
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            seeded_reg <= 1'b0;
            vld_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            seeded_reg <= seeded_next;
            vld_reg    <= vld_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        uns_reg      <= uns_next;
        rd_addr_reg  <= rd_addr_next;
        lane_reg     <= lane_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        unseeded_reg <= unseeded_next;
    end

    sha1csg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .w_in        (blk_word),
        .round_idx   (cnt_reg),
        .word_sel    (cnt_reg[2:0]),
        .digest_word (digest_word)
    );

    sha1csg_ram #(.DEPTH(CHAIN_WORDS), .WIDTH(32)) u_chain_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    sha1csg_ram #(.DEPTH(CHAIN_WORDS), .WIDTH(32)) u_digest_ram (
        .clk   (clk),
        .we    (dg_we),
        .waddr (cnt_reg[2:0]),
        .wdata (digest_word),
        .raddr (dg_raddr),
        .rdata (dg_rdata)
    );

    assign strobe      = strobe_reg;
    assign random_byte = byte_reg;
    assign last_byte   = last_reg;
    assign unseeded    = unseeded_reg;

    `CHK_ALWAYS(a_strobe_in_gen, (!strobe_reg || busy || $past(busy)), "strobe outside generate")
    `CHK_ALWAYS(a_last_has_strobe, (!(strobe_reg && last_reg) || !busy), "last byte while busy")
    `CHK_ALWAYS(a_out_cnt_bound, (state_reg != S_OUT || cnt_reg <= {2'b00, n_reg}), "out count overrun")
    `CHK_NEXT(a_gen_starts, (accept && action == ACT_GEN && byte_count != 5'd0), busy, "generate not started")

endmodule
`default_nettype wire
